/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the checker files of this block.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, muted while the reset is high.
`define ASSERT_CLK_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that must also hold across reset.
`define ASSERT_CLK(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/stns_pkg.sv */
// Shared constants and controller/datapath interface types of the top-N selector.
// No dependencies; compile first.
`timescale 1ns / 1ps
`default_nettype none

package stns_pkg;

   localparam int MAX_KEEP_DEF = 16;
   localparam int ID_BITS_DEF  = 15;
   localparam int SCORE_W      = 16;
   localparam int TOP_N_W      = 5;

   localparam logic [TOP_N_W-1:0] TOP_N_RST = TOP_N_W'(3);

   // Start value of the minimum search: one above every 16-bit score (2.0 in Q1.14).
   localparam logic signed [SCORE_W:0] SCORE_START = {2'b01, {(SCORE_W-1){1'b0}}};

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_item;
      logic scan_init;
      logic scan_run;
      logic inv_mode;
      logic commit;
      logic emit_init;
      logic emit_load;
   } stns_cmd_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      logic scan_done;
      logic item_last;
      logic overflowed;
      logic out_free;
      logic emit_last;
   } stns_status_type;

endpackage

`default_nettype wire

/* hw/rtl/stns_ctrl.sv */
// Controller state machine of the top-N selector: sequences scan, commit and emit.
// Depends on stns_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stns_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  stns_pkg::stns_status_type status,
   output stns_pkg::stns_cmd_type    cmd
);
   import stns_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_SCAN   = 7'b0000010,
      ST_COMMIT = 7'b0000100,
      ST_INVERT = 7'b0001000,
      ST_EADDR  = 7'b0010000,
      ST_ESLOT  = 7'b0100000,
      ST_ELOAD  = 7'b1000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               cmd.scan_init = 1'b1;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_run = 1'b1;
            if (status.scan_done) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            if (!status.item_last) begin
               state_in = ST_IDLE;
            end else if (status.overflowed) begin
               cmd.emit_init = 1'b1;
               state_in      = ST_EADDR;
            end else begin
               cmd.scan_init = 1'b1;
               state_in      = ST_INVERT;
            end
         end
         ST_INVERT: begin
            cmd.scan_run = 1'b1;
            cmd.inv_mode = 1'b1;
            if (status.scan_done) begin
               cmd.emit_init = 1'b1;
               state_in      = ST_EADDR;
            end
         end
         ST_EADDR: begin
            state_in = ST_ESLOT;
         end
         ST_ESLOT: begin
            state_in = ST_ELOAD;
         end
         ST_ELOAD: begin
            cmd.emit_load = 1'b1;
            if (status.out_free) begin
               state_in = status.emit_last ? ST_IDLE : ST_EADDR;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

/* hw/rtl/stns_dpath.sv */
// Datapath of the top-N selector: slot memories, scan unit, rank bookkeeping, output register.
// Depends on stns_pkg; driven by stns_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module stns_dpath #(
   parameter int MAX_KEEP = stns_pkg::MAX_KEEP_DEF,
   parameter int ID_BITS  = stns_pkg::ID_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [stns_pkg::TOP_N_W-1:0]       csr_wdata,
   input  logic [ID_BITS-1:0]                 in_owner,
   input  logic [ID_BITS-1:0]                 in_nb,
   input  logic signed [stns_pkg::SCORE_W-1:0] in_score,
   input  logic                               in_last,
   input  stns_pkg::stns_cmd_type             cmd,
   output stns_pkg::stns_status_type          status,
   output logic                               out_valid,
   input  logic                               out_ready,
   output logic [ID_BITS-1:0]                 out_owner,
   output logic [ID_BITS-1:0]                 out_nb,
   output logic signed [stns_pkg::SCORE_W-1:0] out_score,
   output logic                               out_last
);
   import stns_pkg::*;

   localparam int SLOT_W    = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
   localparam int CNT_W     = $clog2(MAX_KEEP + 1);
   localparam int MEM_DEPTH = 1 << SLOT_W;
   localparam int CMP_W     = (CNT_W > TOP_N_W) ? CNT_W : TOP_N_W;

   // Slot stores and rank bookkeeping
   logic [ID_BITS-1:0]        nb_mem   [MEM_DEPTH];
   logic signed [SCORE_W-1:0] sc_mem   [MEM_DEPTH];
   logic [SLOT_W-1:0]         rank_mem [MEM_DEPTH];  // ascending position of each slot
   logic [SLOT_W-1:0]         inv_mem  [MEM_DEPTH];  // slot held at each position

   logic [ID_BITS-1:0]        nb_rd_ff;
   logic signed [SCORE_W-1:0] sc_rd_ff;
   logic [SLOT_W-1:0]         rank_rd_ff;
   logic [SLOT_W-1:0]         inv_rd_ff;

   // Control registers
   logic [TOP_N_W-1:0] top_n_ff;
   logic [CNT_W-1:0]   fill_ff;
   logic               ovf_ff;
   logic               p_vld_ff;
   logic               out_valid_ff;

   // Payload registers
   logic [ID_BITS-1:0]        run_owner_ff;
   logic [ID_BITS-1:0]        item_nb_ff;
   logic signed [SCORE_W-1:0] item_sc_ff;
   logic                      item_last_ff;
   logic                      mode_fill_ff;
   logic [CNT_W-1:0]          i_ff;
   logic [SLOT_W-1:0]         p_idx_ff;
   logic [SLOT_W-1:0]         cnt_ff;
   logic signed [SCORE_W:0]   lo_ff;
   logic [SLOT_W-1:0]         lo_idx_ff;
   logic [CNT_W-1:0]          j_ff;
   logic [ID_BITS-1:0]        out_owner_ff;
   logic [ID_BITS-1:0]        out_nb_ff;
   logic signed [SCORE_W-1:0] out_sc_ff;
   logic                      out_last_ff;

   logic                      can_fill;
   logic                      issue;
   logic                      proc;
   logic                      out_free;
   logic                      out_load;
   logic                      emit_last;
   logic                      sc_lt_item;
   logic                      sc_lt_lo;
   logic                      item_gt_lo;
   logic signed [SCORE_W:0]   sc_ext;
   logic signed [SCORE_W:0]   item_ext;
   logic [SLOT_W-1:0]         slot_addr;
   logic [SLOT_W-1:0]         sc_addr;
   logic [SLOT_W-1:0]         fill_addr;
   logic                      rank_we;
   logic [SLOT_W-1:0]         rank_wa;
   logic [SLOT_W-1:0]         rank_wd;
   logic                      slot_we;
   logic [SLOT_W-1:0]         slot_wa;

   // Keep size: zero acts as one, anything above MAX_KEEP is capped at MAX_KEEP slots
   assign can_fill = (fill_ff < CNT_W'(MAX_KEEP)) &&
                     ((CMP_W'(fill_ff) < CMP_W'(top_n_ff)) ||
                      ((top_n_ff == '0) && (fill_ff == '0)));

   assign fill_addr  = fill_ff[SLOT_W-1:0];
   assign issue      = cmd.scan_run && (i_ff != fill_ff);
   assign proc       = cmd.scan_run && p_vld_ff;
   assign sc_ext     = {sc_rd_ff[SCORE_W-1], sc_rd_ff};
   assign item_ext   = {item_sc_ff[SCORE_W-1], item_sc_ff};
   assign sc_lt_item = sc_rd_ff < item_sc_ff;
   assign sc_lt_lo   = sc_ext < lo_ff;
   assign item_gt_lo = item_ext > lo_ff;

   assign out_free  = !out_valid_ff || out_ready;
   assign out_load  = cmd.emit_load && out_free;
   assign emit_last = (j_ff + CNT_W'(1)) == fill_ff;
   assign slot_addr = ovf_ff ? j_ff[SLOT_W-1:0] : inv_rd_ff;
   assign sc_addr   = cmd.scan_run ? i_ff[SLOT_W-1:0] : slot_addr;

   // Rank store write: bump ranks of equal-or-higher slots during the scan, place new slot on commit
   always_comb begin
      rank_we = 1'b0;
      rank_wa = fill_addr;
      rank_wd = cnt_ff;
      if (cmd.commit && mode_fill_ff) begin
         rank_we = 1'b1;
      end else if (proc && !cmd.inv_mode && mode_fill_ff && !sc_lt_item) begin
         rank_we = 1'b1;
         rank_wa = p_idx_ff;
         rank_wd = rank_rd_ff + SLOT_W'(1);
      end
   end

   assign slot_we = cmd.commit && (mode_fill_ff || item_gt_lo);
   assign slot_wa = mode_fill_ff ? fill_addr : lo_idx_ff;

   always_ff @(posedge clock) begin
      if (slot_we) begin
         nb_mem[slot_wa] <= item_nb_ff;
         sc_mem[slot_wa] <= item_sc_ff;
      end
      if (rank_we) begin
         rank_mem[rank_wa] <= rank_wd;
      end
      if (proc && cmd.inv_mode) begin
         inv_mem[rank_rd_ff] <= p_idx_ff;
      end
      nb_rd_ff   <= nb_mem[slot_addr];
      sc_rd_ff   <= sc_mem[sc_addr];
      rank_rd_ff <= rank_mem[i_ff[SLOT_W-1:0]];
      inv_rd_ff  <= inv_mem[j_ff[SLOT_W-1:0]];
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         top_n_ff     <= TOP_N_RST;
         fill_ff      <= '0;
         ovf_ff       <= 1'b0;
         p_vld_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
         run_owner_ff <= '0;
      end else begin
         if (csr_we) begin
            top_n_ff <= csr_wdata;
         end
         if (cmd.load_item && (fill_ff == '0) && !ovf_ff) begin
            run_owner_ff <= in_owner;
         end
         p_vld_ff <= issue;
         if (out_load && emit_last) begin
            fill_ff <= '0;
            ovf_ff  <= 1'b0;
         end else begin
            if (cmd.load_item && !can_fill) begin
               ovf_ff <= 1'b1;
            end
            if (cmd.commit && mode_fill_ff) begin
               fill_ff <= fill_ff + CNT_W'(1);
            end
         end
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Item, scan and emit payload
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         item_nb_ff   <= in_nb;
         item_sc_ff   <= in_score;
         item_last_ff <= in_last;
         mode_fill_ff <= can_fill;
      end
      p_idx_ff <= i_ff[SLOT_W-1:0];
      if (cmd.scan_init) begin
         i_ff      <= '0;
         cnt_ff    <= '0;
         lo_ff     <= SCORE_START;
         lo_idx_ff <= '0;
      end else begin
         if (issue) begin
            i_ff <= i_ff + CNT_W'(1);
         end
         if (proc && !cmd.inv_mode) begin
            if (mode_fill_ff) begin
               if (sc_lt_item) begin
                  cnt_ff <= cnt_ff + SLOT_W'(1);
               end
            end else if (sc_lt_lo) begin
               lo_ff     <= sc_ext;
               lo_idx_ff <= p_idx_ff;
            end
         end
      end
      if (cmd.emit_init) begin
         j_ff <= '0;
      end else if (out_load) begin
         j_ff <= j_ff + CNT_W'(1);
      end
      if (out_load) begin
         out_owner_ff <= run_owner_ff;
         out_nb_ff    <= nb_rd_ff;
         out_sc_ff    <= sc_rd_ff;
         out_last_ff  <= emit_last;
      end
   end

   assign status.scan_done  = (i_ff == fill_ff) && !p_vld_ff;
   assign status.item_last  = item_last_ff;
   assign status.overflowed = ovf_ff;
   assign status.out_free   = out_free;
   assign status.emit_last  = emit_last;

   assign out_valid = out_valid_ff;
   assign out_owner = out_owner_ff;
   assign out_nb    = out_nb_ff;
   assign out_score = out_sc_ff;
   assign out_last  = out_last_ff;

endmodule

`default_nettype wire

/* hw/rtl/streaming_top_n_selector.sv */
// Top level of the streaming top-N selector: stream ports, field packing, controller and datapath.
// Depends on stns_pkg, stns_ctrl and stns_dpath.
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Transaction carries
// req_*    in         one candidate: owner_id, neighbor_id, score; tlast ends the owner run
// rsp_*    out        one kept entry: owner_id_out, neighbor_id_out, score_out; tlast on final one
// csr_*    in         top_n write, taken on any clock with csr_we high
//
// A candidate holds req_tready low after acceptance while the slot-score memory read port
// walks the F slots already held, one slot per cycle, for the fill rank count or the minimum
// search. The last candidate of a run that never overflowed adds a second walk to invert the
// rank order; each run end takes every emitted entry through address, slot and load states
// and any output stall. Reset is synchronous; the slot memories are not cleared, the fill
// count guards them. req_tready stays low until the whole emission is loaded into the
// output.
module streaming_top_n_selector #(
   parameter int MAX_KEEP = stns_pkg::MAX_KEEP_DEF,
   parameter int ID_BITS  = stns_pkg::ID_BITS_DEF
) (
   input  logic                                                 clock,
   input  logic                                                 reset,
   input  logic                                                 csr_we,
   input  logic [stns_pkg::TOP_N_W-1:0]                         csr_wdata,  // top_n
   input  logic                                                 req_tvalid,
   output logic                                                 req_tready,
   // owner_id, neighbor_id, score (lowest bits first), zero padded to bytes
   input  logic [((2*ID_BITS+stns_pkg::SCORE_W+7)/8)*8-1:0]     req_tdata,
   input  logic                                                 req_tlast,
   output logic                                                 rsp_tvalid,
   input  logic                                                 rsp_tready,
   // owner_id_out, neighbor_id_out, score_out (lowest bits first), zero padded to bytes
   output logic [((2*ID_BITS+stns_pkg::SCORE_W+7)/8)*8-1:0]     rsp_tdata,
   output logic                                                 rsp_tlast
);
   import stns_pkg::*;

   localparam int DATA_W = ((2*ID_BITS+SCORE_W+7)/8)*8;

   stns_cmd_type    cmd;
   stns_status_type status;

   logic [ID_BITS-1:0]        in_owner;
   logic [ID_BITS-1:0]        in_nb;
   logic signed [SCORE_W-1:0] in_score;
   logic [ID_BITS-1:0]        out_owner;
   logic [ID_BITS-1:0]        out_nb;
   logic signed [SCORE_W-1:0] out_score;

   // Unpack the request fields; padding bits are ignored
   assign in_owner = req_tdata[ID_BITS-1:0];
   assign in_nb    = req_tdata[2*ID_BITS-1:ID_BITS];
   assign in_score = $signed(req_tdata[2*ID_BITS+SCORE_W-1:2*ID_BITS]);

   stns_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   stns_dpath #(
      .MAX_KEEP (MAX_KEEP),
      .ID_BITS  (ID_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .in_owner  (in_owner),
      .in_nb     (in_nb),
      .in_score  (in_score),
      .in_last   (req_tlast),
      .cmd       (cmd),
      .status    (status),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_owner (out_owner),
      .out_nb    (out_nb),
      .out_score (out_score),
      .out_last  (rsp_tlast)
   );

   // Pack the response fields, zero fill above
   assign rsp_tdata = DATA_W'({out_score, out_nb, out_owner});

endmodule

`default_nettype wire

/* hw/rtl/stns_checker.sv */
// Port-level checker of the top-N selector, bound to the top level.
// Depends on stns_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module stns_checker #(
   parameter int ID_BITS = stns_pkg::ID_BITS_DEF
) (
   input logic                                             clock,
   input logic                                             reset,
   input logic                                             req_tvalid,
   input logic                                             req_tready,
   input logic                                             rsp_tvalid,
   input logic                                             rsp_tready,
   input logic [((2*ID_BITS+stns_pkg::SCORE_W+7)/8)*8-1:0] rsp_tdata,
   input logic                                             rsp_tlast
);
   import stns_pkg::*;

   // Reset drops any pending result
   `ASSERT_CLK(a_rst_drop, clock, reset |=> !rsp_tvalid, "result valid survived reset")

   // A stalled result holds its payload
   `ASSERT_CLK_RST(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "stalled result changed")

   // Each candidate occupies at least the scan and commit states before the next is taken
   `ASSERT_CLK_RST(a_req_busy, clock, reset, req_tvalid && req_tready |=> !req_tready ##1 !req_tready, "candidate taken too early")

endmodule

bind streaming_top_n_selector stns_checker #(
   .ID_BITS (ID_BITS)
) u_stns_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

/* test/streaming_top_n_selector_tb.sv */
// Self-checking testbench for streaming_top_n_selector: directed table, then random runs.
// Depends on stns_pkg and the selector RTL; prediction is done by an in-bench top-N model.
`timescale 1ns / 1ps

module streaming_top_n_selector_tb;

   import stns_pkg::*;

   localparam int ID_W     = stns_pkg::ID_BITS_DEF;
   localparam int KEEP_MAX = stns_pkg::MAX_KEEP_DEF;
   localparam int DATA_W   = ((2*ID_W+SCORE_W+7)/8)*8;

   // One above every 16-bit score; the minimum search always finds a slot below it.
   localparam int SCORE_CEIL    = 32768;
   // Cycles to let the block finish a candidate that emits nothing (F <= 16).
   localparam int SETTLE_CYCLES = 64;
   localparam int HOLD_CYCLES   = 400;
   localparam int LIMIT_CYCLES  = 500000;
   localparam int REPORT_MAX    = 10;

   typedef struct packed {
      logic [ID_W-1:0]    owner;
      logic [ID_W-1:0]    nb;
      logic [SCORE_W-1:0] score;
      logic               last;
   } kept_entry_type;

   typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_type;

   typedef struct packed {
      row_kind_type       kind;
      logic [TOP_N_W-1:0] keep;
      logic [ID_W-1:0]    owner;
      logic [ID_W-1:0]    nb;
      logic [SCORE_W-1:0] score;
      logic               last;
      logic               typed;   // want holds the single result of a one-result run
      kept_entry_type     want;
   } plan_row_type;

   // Directed plan. Typed rows carry their result; all others go through the predictor.
   localparam plan_row_type PLAN [28] = '{
      // single-candidate runs at reset keep size: zeros, all-ones ids, both score extremes
      '{ROW_ITEM, 5'd0, 15'h0000, 15'h0000, 16'h0000, 1'b1, 1'b1,
        '{15'h0000, 15'h0000, 16'h0000, 1'b1}},
      '{ROW_ITEM, 5'd0, 15'h7FFF, 15'h7FFF, 16'h7FFF, 1'b1, 1'b1,
        '{15'h7FFF, 15'h7FFF, 16'h7FFF, 1'b1}},
      '{ROW_ITEM, 5'd0, 15'h2AAA, 15'h5555, 16'h8000, 1'b1, 1'b1,
        '{15'h2AAA, 15'h5555, 16'h8000, 1'b1}},
      // equal scores without overflow: the later one ranks first
      '{ROW_ITEM, 5'd0, 15'h0123, 15'h0001, 16'h0100, 1'b0, 1'b0, '0},
      '{ROW_ITEM, 5'd0, 15'h0123, 15'h0002, 16'h0100, 1'b0, 1'b0, '0},
      '{ROW_ITEM, 5'd0, 15'h0123, 15'h0003, 16'hC000, 1'b1, 1'b0, '0},
      // overflow, tie in the minimum search, equal score dropped, owner varying
      '{ROW_ITEM, 5'd0, 15'h0456, 15'h0010, 16'h4000, 1'b0, 1'b0, '0},
      '{ROW_ITEM, 5'd0, 15'h0457, 15'h0011, 16'h8000, 1'b0, 1'b0, '0},
      '{ROW_ITEM, 5'd0, 15'h0458, 15'h0012, 16'h8000, 1'b0, 1'b0, '0},
      '{ROW_ITEM, 5'd0, 15'h0459, 15'h0013, 16'h8000, 1'b0, 1'b0, '0},
      '{ROW_ITEM, 5'd0, 15'h045A, 15'h0014, 16'h8001, 1'b1, 1'b0, '0},
      // keep size zero acts as one: the best score survives
      '{ROW_CFG,  5'd0, 15'h0000, 15'h0000, 16'h0000, 1'b0, 1'b0, '0},
      '{ROW_ITEM, 5'd0, 15'h0789, 15'h0020, 16'h0005, 1'b0, 1'b0, '0},
      '{ROW_ITEM, 5'd0, 15'h0789, 15'h0021, 16'h0009, 1'b0, 1'b0, '0},
      '{ROW_ITEM, 5'd0, 15'h0789, 15'h0022, 16'h0007, 1'b1, 1'b1,
        '{15'h0789, 15'h0021, 16'h0009, 1'b1}},
      // keep size above the slot count acts as the slot count
      '{ROW_CFG,  5'd31, 15'h0000, 15'h0000, 16'h0000, 1'b0, 1'b0, '0},
      '{ROW_ITEM, 5'd0, 15'h1000, 15'h0030, 16'h3000, 1'b1, 1'b1,
        '{15'h1000, 15'h0030, 16'h3000, 1'b1}},
      // keep size raised in the middle of a run: filling goes on
      '{ROW_CFG,  5'd2, 15'h0000, 15'h0000, 16'h0000, 1'b0, 1'b0, '0},
      '{ROW_ITEM, 5'd0, 15'h1111, 15'h0040, 16'h0010, 1'b0, 1'b0, '0},
      '{ROW_ITEM, 5'd0, 15'h1111, 15'h0041, 16'h0020, 1'b0, 1'b0, '0},
      '{ROW_CFG,  5'd4, 15'h0000, 15'h0000, 16'h0000, 1'b0, 1'b0, '0},
      '{ROW_ITEM, 5'd0, 15'h1111, 15'h0042, 16'hFFF0, 1'b0, 1'b0, '0},
      '{ROW_ITEM, 5'd0, 15'h1111, 15'h0043, 16'h0020, 1'b1, 1'b0, '0},
      // keep size cut in the middle of a run: replace among all filled slots
      '{ROW_ITEM, 5'd0, 15'h2222, 15'h0050, 16'h0100, 1'b0, 1'b0, '0},
      '{ROW_ITEM, 5'd0, 15'h2222, 15'h0051, 16'h0080, 1'b0, 1'b0, '0},
      '{ROW_ITEM, 5'd0, 15'h2222, 15'h0052, 16'h0200, 1'b0, 1'b0, '0},
      '{ROW_CFG,  5'd1, 15'h0000, 15'h0000, 16'h0000, 1'b0, 1'b0, '0},
      '{ROW_ITEM, 5'd0, 15'h2222, 15'h0053, 16'h0180, 1'b1, 1'b0, '0}
   };

   // Scores that make ties and extremes likely in random runs.
   localparam logic [SCORE_W-1:0] HOT_SCORES [6] = '{
      16'h8000, 16'h7FFF, 16'hC000, 16'h4000, 16'h0000, 16'h0001
   };

   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               csr_we     = 1'b0;
   logic [TOP_N_W-1:0] csr_wdata  = '0;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [DATA_W-1:0]  req_tdata  = '0;  // owner_id, neighbor_id, score, zero pad
   logic               req_tlast  = 1'b0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [DATA_W-1:0]  rsp_tdata;        // owner_id_out, neighbor_id_out, score_out, zero pad
   logic               rsp_tlast;

   // Predictor state: slots, rank order, fill level, overflow flag, latched owner.
   logic [TOP_N_W-1:0]        top_n_r = TOP_N_RST;
   logic [ID_W-1:0]           slot_nb [KEEP_MAX];
   logic signed [SCORE_W-1:0] slot_sc [KEEP_MAX];
   int                        rank_ix [KEEP_MAX];
   int                        fill_cnt = 0;
   bit                        ovf = 1'b0;
   logic [ID_W-1:0]           run_own = '0;

   kept_entry_type kept_q [$];
   int             fault_cnt = 0;
   int             cycle_cnt = 0;
   int             snd_idle_pct = 0;
   int             rcv_stall_pct = 0;
   int             hold_ask = 0;
   int             hold_seen = 0;
   int             hold_left = 0;

   streaming_top_n_selector DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int effective_keep(input logic [TOP_N_W-1:0] v);
      if (v == 0) return 1;
      if (v > KEEP_MAX) return KEEP_MAX;
      return int'(v);
   endfunction

   // Update the top-N state with one candidate; on the run's last candidate return
   // the kept entries in emission order.
   function automatic void rank_candidate(input logic [ID_W-1:0] own,
                                          input logic [ID_W-1:0] nb,
                                          input logic signed [SCORE_W-1:0] sc,
                                          input logic lst,
                                          ref kept_entry_type burst [$]);
      int             keep;
      int             pos;
      int             lo;
      int             lo_ix;
      int             s;
      kept_entry_type e;
      keep = effective_keep(top_n_r);
      burst.delete();
      if (fill_cnt == 0 && !ovf) run_own = own;
      if (fill_cnt < keep) begin
         slot_nb[fill_cnt] = nb;
         slot_sc[fill_cnt] = sc;
         // insert ahead of the first ranked slot that scores at least as high
         pos = 0;
         while (pos < fill_cnt && slot_sc[rank_ix[pos]] < sc) pos++;
         for (int j = fill_cnt; j > pos; j--) rank_ix[j] = rank_ix[j-1];
         rank_ix[pos] = fill_cnt;
         fill_cnt++;
      end else begin
         ovf = 1'b1;
         lo = SCORE_CEIL;
         lo_ix = 0;
         for (int j = 0; j < fill_cnt; j++) begin
            if (slot_sc[j] < lo) begin
               lo = slot_sc[j];
               lo_ix = j;
            end
         end
         if (sc > lo) begin
            slot_sc[lo_ix] = sc;
            slot_nb[lo_ix] = nb;
         end
      end
      if (!lst) return;
      for (int j = 0; j < fill_cnt; j++) begin
         s = ovf ? j : rank_ix[j];
         e.owner = run_own;
         e.nb    = slot_nb[s];
         e.score = slot_sc[s];
         e.last  = (j == fill_cnt - 1);
         burst.push_back(e);
      end
      fill_cnt = 0;
      ovf = 1'b0;
   endfunction

   // Offer one candidate, hold it until the handshake, then log its expected results.
   task automatic offer_candidate(input logic [ID_W-1:0] own, input logic [ID_W-1:0] nb,
                                  input logic [SCORE_W-1:0] sc, input logic lst,
                                  input logic typed, input kept_entry_type want);
      kept_entry_type burst [$];
      while ($urandom_range(99) < snd_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= DATA_W'({sc, nb, own});
      req_tlast  <= lst;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      rank_candidate(own, nb, sc, lst, burst);
      if (typed) kept_q.push_back(want);
      else foreach (burst[i]) kept_q.push_back(burst[i]);
   endtask

   // Stop offering, wait for every expected entry, then let the block settle.
   task automatic await_kept_drain();
      req_tvalid <= 1'b0;
      while (kept_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_top_n(input logic [TOP_N_W-1:0] v);
      await_kept_drain();
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
      top_n_r = v;
   endtask

   // One owner run of random length and content; mostly within the keep size,
   // some overflowing, now and then a stray owner inside the run.
   task automatic random_run(input int max_len, output int len);
      int              keep;
      logic [ID_W-1:0] own;
      logic [ID_W-1:0] item_own;
      logic [SCORE_W-1:0] sc;
      keep = effective_keep(top_n_r);
      len = ($urandom_range(9) < 7) ? $urandom_range(keep, 1)
                                    : $urandom_range(keep + 6, keep + 1);
      if (len > max_len) len = max_len;
      own = ID_W'($urandom);
      for (int i = 0; i < len; i++) begin
         item_own = ($urandom_range(9) == 0) ? ID_W'($urandom) : own;
         sc = ($urandom_range(9) < 3) ? HOT_SCORES[$urandom_range(5)] : SCORE_W'($urandom);
         offer_candidate(item_own, ID_W'($urandom), sc, i == len - 1, 1'b0, '0);
      end
   endtask

   // Receiver: random stalls, or a long hold-off when the stimulus asks for one.
   always @(posedge clock) begin
      if (hold_ask != hold_seen) begin
         hold_seen = hold_ask;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rcv_stall_pct);
      end
   end

   // Compare each kept entry with the oldest expectation.
   always @(posedge clock) begin
      kept_entry_type got;
      kept_entry_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.owner = rsp_tdata[ID_W-1:0];
         got.nb    = rsp_tdata[2*ID_W-1:ID_W];
         got.score = rsp_tdata[2*ID_W+SCORE_W-1:2*ID_W];
         got.last  = rsp_tlast;
         if (kept_q.size() == 0) begin
            fault_cnt++;
            if (fault_cnt <= REPORT_MAX)
               $display("unexpected entry: owner %h neighbor %h score %h last %b",
                        got.owner, got.nb, got.score, got.last);
         end else begin
            want = kept_q.pop_front();
            if (got.owner !== want.owner || got.nb !== want.nb ||
                got.score !== want.score || got.last !== want.last) begin
               fault_cnt++;
               if (fault_cnt <= REPORT_MAX)
                  $display("entry mismatch: expected %h %h %h %b, got %h %h %h %b",
                           want.owner, want.nb, want.score, want.last,
                           got.owner, got.nb, got.score, got.last);
            end
         end
      end
   end

   // Watchdog: end the run if it hangs.
   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt > LIMIT_CYCLES) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      int snd_pct [4];
      int rcv_pct [4];
      int keep_pick [4];
      int sent;
      int len;
      snd_pct   = '{0, 82, 0, 31};
      rcv_pct   = '{0, 0, 82, 31};
      keep_pick = '{16, 1, $urandom_range(15, 2), $urandom_range(31, 0)};

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed table, no idling
      for (int i = 0; i < $size(PLAN); i++) begin
         if (PLAN[i].kind == ROW_CFG)
            write_top_n(PLAN[i].keep);
         else
            offer_candidate(PLAN[i].owner, PLAN[i].nb, PLAN[i].score, PLAN[i].last,
                            PLAN[i].typed, PLAN[i].want);
      end

      // random phases, each with its own idling mix and keep size
      for (int p = 0; p < 4; p++) begin
         write_top_n(TOP_N_W'(keep_pick[p]));
         snd_idle_pct  = snd_pct[p];
         rcv_stall_pct = rcv_pct[p];
         sent = 0;
         while (sent < 15) begin
            random_run(KEEP_MAX + 6, len);
            sent += len;
         end
         if (p == 0) begin
            // hold the receiver off while short runs keep coming: fill the block
            hold_ask++;
            for (int r = 0; r < 8; r++) random_run(2, len);
            await_kept_drain();
         end
      end

      await_kept_drain();
      if (fault_cnt == 0 && kept_q.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
